// ----- design/lcwrt_pkg.sv -----
// ----------------------------------------------------------------------------
// lcwrt_pkg
// Shared types and constants for the load-cell weight and rate tracker.
// ----------------------------------------------------------------------------
package lcwrt_pkg;

    localparam int unsigned W_WEIGHT = 40;
    localparam int unsigned W_RAW    = 24;
    localparam int unsigned W_TIME   = 32;
    localparam int unsigned W_SCALE  = 30;
    localparam int unsigned W_CFG    = 20;
    localparam int unsigned W_KNOWN  = 20;

    // Divider operand widths: numerator magnitude and denominator
    localparam int unsigned W_NUM = 64;
    localparam int unsigned W_DEN = 32;

    localparam logic [W_SCALE-1:0] SCALE_RESET = 30'd4096;

    localparam logic [15:0]      POLL_RESET    = 16'd500;
    localparam logic [W_CFG-1:0] SILENCE_RESET = 20'd10000;
    localparam logic [W_CFG-1:0] HIST_RESET    = 20'd30000;
    localparam logic [W_CFG-1:0] SPAN_RESET    = 20'd54000;

    // Item kinds
    localparam logic [1:0] KIND_POLL = 2'd0;
    localparam logic [1:0] KIND_TARE = 2'd1;
    localparam logic [1:0] KIND_CAL  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_APPLIED   = 2'd0;
    localparam logic [1:0] ST_THROTTLED = 2'd1;
    localparam logic [1:0] ST_MISSED    = 2'd2;
    localparam logic [1:0] ST_REJECTED  = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_POLL    = 2'd0;
    localparam logic [1:0] REG_SILENCE = 2'd1;
    localparam logic [1:0] REG_HIST    = 2'd2;
    localparam logic [1:0] REG_SPAN    = 2'd3;

    localparam logic signed [W_WEIGHT-1:0] W40_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [W_WEIGHT-1:0] W40_MIN = 40'sh8000000000;

endpackage

// ----- design/load_cell_weight_rate_tracker_top.sv -----
// ----------------------------------------------------------------------------
// load_cell_weight_rate_tracker_top
// Load-cell tracker: throttle, health, tare, calibrate, weight and rate,
// with a small sequencer around one shared serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, kind..known_grams      | into block
//  out     | out_valid/out_ready, weight..status       | out of block
//  cfg     | cfg_we, cfg_index, cfg_data               | into block
//
// Poll with a good read: the weight division (when the scale is nonzero),
// then the ring write and, when it updates the rate, a rate division.
// Calibrate runs one division; other items go straight to the result. The
// 64-step divider does the divisions. No clearing pass after reset. in_ready
// is low from acceptance until the result register is free again; the
// result waits for out_ready.
module load_cell_weight_rate_tracker_top #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] now_ms,
    input  logic        data_ready,
    input  logic signed [23:0] raw_sample,
    input  logic [19:0] known_grams,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [39:0] weight_grams,
    output logic signed [39:0] rate_grams_per_min,
    output logic        rate_valid,
    output logic        sensor_ok,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import lcwrt_pkg::*;

    localparam int unsigned W_IDX = $clog2(HISTORY_DEPTH);
    localparam int unsigned W_CNT = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WDIV, S_WWAIT, S_RING, S_RREAD, S_RCHK,
        S_RDIV, S_RWAIT, S_CDIV, S_CWAIT, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration
    logic [15:0]      poll_reg;
    logic [W_CFG-1:0] silence_reg, hist_reg, span_reg;

    // Captured item
    logic [1:0]  kind_reg;
    logic [31:0] now_reg;
    logic        rdy_reg;
    logic signed [23:0] raw_in_reg;
    logic [19:0] known_reg;

    // Tracker state
    logic        healthy_reg, try_seen_reg, rate_known_reg, sample_seen_reg;
    logic [31:0] try_time_reg, ok_time_reg, sample_time_reg;
    logic signed [23:0] last_raw_reg, offset_reg;
    logic [W_SCALE-1:0] scale_reg;
    logic signed [39:0] weight_reg, rate_reg;
    logic [W_IDX-1:0] slot_reg;
    logic [W_CNT-1:0] held_reg;

    // History ring
    logic signed [39:0] hw_mem [HISTORY_DEPTH];
    logic [31:0]        ht_mem [HISTORY_DEPTH];
    logic signed [39:0] old_w_reg;
    logic [31:0]        old_t_reg;
    logic [W_IDX-1:0]   old_idx;

    // Output register
    logic        ov_reg;
    logic [1:0]  st_reg;

    // Divider
    logic             div_start;
    logic             div_neg;
    logic [W_NUM-1:0] div_mag;
    logic [W_DEN-1:0] div_den;
    logic             div_done;
    logic signed [39:0] div_res;

    logic signed [24:0] diff;
    logic signed [25:0] diff_now;
    logic [31:0]  dt;
    logic signed [40:0] dw;
    logic signed [63:0] num;
    logic signed [44:0] d20;
    logic signed [44:0] k20;
    logic [19:0] slot_sum;

    lcwrt_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .neg(div_neg),
        .mag(div_mag), .den(div_den), .done(div_done), .result(div_res)
    );

    // Combinational helpers
    always_comb
    begin
        diff     = 25'(last_raw_reg) - 25'(offset_reg);
        diff_now = 26'(raw_in_reg) - 26'(offset_reg);
        dt       = now_reg - old_t_reg;
        dw       = 41'(weight_reg) - 41'(old_w_reg);
        d20      = 45'(diff) * 45'sd20;
        k20      = 45'(signed'({1'b0, known_reg})) * 45'sd200000;
        slot_sum = 20'(slot_reg) + 20'(HISTORY_DEPTH) - 20'(held_reg);
        old_idx  = (slot_sum >= 20'(HISTORY_DEPTH))
                 ? W_IDX'(slot_sum - 20'(HISTORY_DEPTH)) : W_IDX'(slot_sum);
        num      = '0;
        div_den  = '0;
        div_start = 1'b0;
        unique case (state_reg)
            S_WDIV:
            begin
                num       = 64'(diff_now) <<< 20;
                div_den   = 32'(scale_reg);
                div_start = 1'b1;
            end
            S_RDIV:
            begin
                num       = 64'(dw) * 64'sd60000;
                div_den   = dt;
                div_start = 1'b1;
            end
            S_CDIV:
            begin
                num       = 64'(diff) <<< 12;
                div_den   = 32'(known_reg);
                div_start = 1'b1;
            end
            default: ;
        endcase
        div_neg = num[63];
        div_mag = num[63] ? (~num + 64'd1) : num;
    end

    // History ring storage
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RING)
        begin
            hw_mem[slot_reg] <= weight_reg;
            ht_mem[slot_reg] <= now_reg;
        end
        if (state_reg == S_RREAD)
        begin
            old_w_reg <= hw_mem[old_idx];
            old_t_reg <= ht_mem[old_idx];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg    <= POLL_RESET;
            silence_reg <= SILENCE_RESET;
            hist_reg    <= HIST_RESET;
            span_reg    <= SPAN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLL:    poll_reg    <= cfg_data[15:0];
                REG_SILENCE: silence_reg <= cfg_data;
                REG_HIST:    hist_reg    <= cfg_data;
                REG_SPAN:    span_reg    <= cfg_data;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg   <= kind;
            now_reg    <= now_ms;
            rdy_reg    <= data_ready;
            raw_in_reg <= raw_sample;
            known_reg  <= known_grams;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            healthy_reg     <= 1'b0;
            try_seen_reg    <= 1'b0;
            try_time_reg    <= '0;
            ok_time_reg     <= '0;
            last_raw_reg    <= '0;
            offset_reg      <= '0;
            scale_reg       <= SCALE_RESET;
            weight_reg      <= '0;
            rate_reg        <= '0;
            rate_known_reg  <= 1'b0;
            sample_time_reg <= '0;
            sample_seen_reg <= 1'b0;
            slot_reg        <= '0;
            held_reg        <= '0;
            ov_reg          <= 1'b0;
            st_reg          <= ST_APPLIED;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                        state_reg <= S_DECODE;
                S_DECODE:
                begin
                    priority if (kind_reg == KIND_POLL)
                    begin
                        if (try_seen_reg && ((now_reg - try_time_reg) < 32'(poll_reg)))
                        begin
                            st_reg    <= ST_THROTTLED;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            try_seen_reg <= 1'b1;
                            try_time_reg <= now_reg;
                            if (!rdy_reg)
                            begin
                                if (healthy_reg && ((now_reg - ok_time_reg) > 32'(silence_reg)))
                                    healthy_reg <= 1'b0;
                                st_reg    <= ST_MISSED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                healthy_reg  <= 1'b1;
                                ok_time_reg  <= now_reg;
                                last_raw_reg <= raw_in_reg;
                                st_reg       <= ST_APPLIED;
                                state_reg    <= (scale_reg != '0) ? S_WDIV : S_RING;
                            end
                        end
                    end
                    else if (kind_reg == KIND_TARE)
                    begin
                        state_reg <= S_DONE;
                        if (!healthy_reg)
                            st_reg <= ST_REJECTED;
                        else
                        begin
                            st_reg         <= ST_APPLIED;
                            offset_reg     <= last_raw_reg;
                            weight_reg     <= '0;
                            held_reg       <= '0;
                            slot_reg       <= '0;
                            rate_reg       <= '0;
                            rate_known_reg <= 1'b0;
                        end
                    end
                    else if (kind_reg == KIND_CAL)
                    begin
                        if (!healthy_reg || known_reg == '0
                            || d20 <= 45'(signed'({1'b0, known_reg}))
                            || 45'(diff) >= k20)
                        begin
                            st_reg    <= ST_REJECTED;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            st_reg    <= ST_APPLIED;
                            state_reg <= S_CDIV;
                        end
                    end
                    else
                    begin
                        st_reg    <= ST_REJECTED;
                        state_reg <= S_DONE;
                    end
                end
                S_WDIV:  state_reg <= S_WWAIT;
                S_WWAIT:
                    if (div_done)
                    begin
                        weight_reg <= div_res;
                        state_reg  <= S_RING;
                    end
                S_RING:
                    if (!sample_seen_reg || ((now_reg - sample_time_reg) >= 32'(hist_reg)))
                    begin
                        sample_time_reg <= now_reg;
                        sample_seen_reg <= 1'b1;
                        slot_reg  <= (slot_reg == W_IDX'(HISTORY_DEPTH - 1))
                                   ? '0 : slot_reg + 1'b1;
                        if (held_reg < W_CNT'(HISTORY_DEPTH))
                            held_reg <= held_reg + 1'b1;
                        state_reg <= S_RREAD;
                    end
                    else
                        state_reg <= S_DONE;
                S_RREAD:
                    state_reg <= (held_reg >= W_CNT'(3)) ? S_RCHK : S_DONE;
                S_RCHK:
                    state_reg <= (dt != '0 && dt >= 32'(span_reg)) ? S_RDIV : S_DONE;
                S_RDIV:  state_reg <= S_RWAIT;
                S_RWAIT:
                    if (div_done)
                    begin
                        rate_reg       <= div_res;
                        rate_known_reg <= 1'b1;
                        state_reg      <= S_DONE;
                    end
                S_CDIV:  state_reg <= S_CWAIT;
                S_CWAIT:
                    if (div_done)
                    begin
                        scale_reg <= div_res[W_SCALE-1:0];
                        state_reg <= S_DONE;
                    end
                S_DONE:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready           = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid          = ov_reg;
    assign weight_grams       = weight_reg;
    assign rate_grams_per_min = rate_known_reg ? rate_reg : '0;
    assign rate_valid         = rate_known_reg;
    assign sensor_ok          = healthy_reg;
    assign status             = st_reg;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready with result pending");
    a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= W_CNT'(HISTORY_DEPTH)) else $error("ring count overflow");
    a_rate_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !rate_known_reg |-> rate_grams_per_min == '0) else $error("stale rate");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> out_valid) else $error("result not shown");
`endif
endmodule

// ----- design/lcwrt_div.sv -----
// ----------------------------------------------------------------------------
// lcwrt_div
// Restoring radix-2 divider, one quotient bit per cycle, rounding to nearest
// with ties away from zero and saturating to the signed 40-bit range.
// ----------------------------------------------------------------------------
module lcwrt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       neg,
    input  logic [lcwrt_pkg::W_NUM-1:0] mag,
    input  logic [lcwrt_pkg::W_DEN-1:0] den,
    output logic                       done,
    output logic signed [lcwrt_pkg::W_WEIGHT-1:0] result
);
    import lcwrt_pkg::*;

    localparam int unsigned W_CNT = $clog2(W_NUM + 1);

    logic [W_NUM-1:0]   quo_reg;
    logic [W_DEN:0]     rem_reg;
    logic [W_DEN-1:0]   den_reg;
    logic               neg_reg;
    logic [W_CNT-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [W_DEN+1:0]   trial;
    logic [W_DEN:0]     shifted;
    logic [W_DEN:0]     twice_rem;
    logic               round_up;
    logic [W_NUM:0]     q_round;
    logic [W_WEIGHT-1:0] q_sat;

    // One shift-subtract step
    always_comb
    begin
        shifted = {rem_reg[W_DEN-1:0], quo_reg[W_NUM-1]};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
    end

    // Round: remainder*2 >= divisor means round up (ties away from zero)
    always_comb
    begin
        twice_rem = {rem_reg[W_DEN-1:0], 1'b0};
        round_up  = rem_reg[W_DEN] || (twice_rem >= {1'b0, den_reg});
        q_round   = {1'b0, quo_reg} + {{W_NUM{1'b0}}, round_up};
        if (q_round > {{(W_NUM+1-W_WEIGHT){1'b0}}, W40_MAX})
            q_sat = neg_reg ? W40_MIN : W40_MAX;
        else
            q_sat = neg_reg ? (~q_round[W_WEIGHT-1:0] + 1'b1) : q_round[W_WEIGHT-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= W_CNT'(W_NUM);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == W_CNT'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            if (!trial[W_DEN+1])
            begin
                rem_reg <= trial[W_DEN:0];
                quo_reg <= {quo_reg[W_NUM-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W_NUM-2:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = q_sat;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("div done held");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("div restarted while busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("div busy at done");
`endif
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the load-cell weight and rate tracker. A behavioral predictor
// tracks health, throttling, tare, calibration, the history ring and the rate.
// Directed tests cover corner cases, then random traffic runs under several
// register settings, mostly with both handshake sides idling at random. Every
// result transaction is compared field by field against the predicted queue.
// ----------------------------------------------------------------------------
module tb_top;
    import lcwrt_pkg::*;

    localparam int RING_DEPTH = 10;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] kind;
    logic [31:0] now_ms;
    logic data_ready;
    logic signed [23:0] raw_sample;
    logic [19:0] known_grams;
    logic out_valid;
    logic out_ready;
    logic signed [39:0] weight_grams;
    logic signed [39:0] rate_grams_per_min;
    logic rate_valid;
    logic sensor_ok;
    logic [1:0] status;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [19:0] cfg_data;

    typedef struct packed {
        logic signed [39:0] weight;
        logic signed [39:0] rate;
        logic               rate_ok;
        logic               healthy;
        logic [1:0]         st;
    } tracker_result_t;

    tracker_result_t pending_results[$];
    int  error_count;
    int  results_seen;
    int  holdoff_cycles;
    int  rate_updates;
    bit  rx_idle_on;
    bit  tx_idle_on;

    // Predictor state
    logic [15:0] p_poll_iv;
    logic [19:0] p_silence;
    logic [19:0] p_hist_iv;
    logic [19:0] p_span;
    bit          p_healthy;
    logic [31:0] p_last_try;
    bit          p_try_seen;
    logic [31:0] p_last_ok;
    logic signed [23:0] p_last_raw;
    logic signed [23:0] p_offset;
    logic [29:0] p_scale;
    logic signed [39:0] p_weight;
    logic signed [39:0] p_rate;
    bit          p_rate_known;
    logic [31:0] p_last_sample;
    bit          p_sample_seen;
    logic signed [39:0] p_ring_w[RING_DEPTH];
    logic [31:0] p_ring_t[RING_DEPTH];
    int          p_slot;
    int          p_held;

    // Stimulus time base
    logic [31:0] clock_ms;

    load_cell_weight_rate_tracker_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .now_ms(now_ms), .data_ready(data_ready),
        .raw_sample(raw_sample), .known_grams(known_grams),
        .out_valid(out_valid), .out_ready(out_ready),
        .weight_grams(weight_grams), .rate_grams_per_min(rate_grams_per_min),
        .rate_valid(rate_valid), .sensor_ok(sensor_ok), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("[load_cell_weight_rate_tracker_top] ERROR");
        $finish;
    end

    // Rounded division, ties away from zero; clamp40 then saturates like the block
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (q > (64'sd1 <<< 41))
            q = 64'sd1 <<< 41;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [39:0] clamp40(input longint v);
        if (v > longint'(W40_MAX))
            return W40_MAX;
        if (v < longint'(W40_MIN))
            return W40_MIN;
        return v[39:0];
    endfunction

    function automatic void tracker_reset();
        p_poll_iv = POLL_RESET;
        p_silence = SILENCE_RESET;
        p_hist_iv = HIST_RESET;
        p_span = SPAN_RESET;
        p_healthy = 0;
        p_last_try = '0;
        p_try_seen = 0;
        p_last_ok = '0;
        p_last_raw = '0;
        p_offset = '0;
        p_scale = SCALE_RESET;
        p_weight = '0;
        p_rate = '0;
        p_rate_known = 0;
        p_last_sample = '0;
        p_sample_seen = 0;
        p_slot = 0;
        p_held = 0;
    endfunction

    // Ring write and rate update
    function automatic void history_push(input logic [31:0] t);
        int newest;
        int oldest;
        logic [31:0] dt;
        longint dw;
        p_last_sample = t;
        p_sample_seen = 1;
        p_ring_w[p_slot] = p_weight;
        p_ring_t[p_slot] = t;
        p_slot = (p_slot + 1) % RING_DEPTH;
        if (p_held < RING_DEPTH)
            p_held++;
        if (p_held < 3)
            return;
        newest = (p_slot + RING_DEPTH - 1) % RING_DEPTH;
        oldest = (p_slot + RING_DEPTH - p_held) % RING_DEPTH;
        dt = p_ring_t[newest] - p_ring_t[oldest];
        if (dt != 0 && dt >= {12'd0, p_span})
        begin
            dw = longint'(p_ring_w[newest]) - longint'(p_ring_w[oldest]);
            p_rate = clamp40(div_nearest(dw * 60000, longint'({32'd0, dt})));
            p_rate_known = 1;
            rate_updates++;
        end
    endfunction

    function automatic tracker_result_t tracker_step(input logic [1:0] k,
            input logic [31:0] t, input logic rdy, input logic signed [23:0] raw,
            input logic [19:0] grams);
        tracker_result_t r;
        logic [1:0] st;
        longint diff;
        st = ST_APPLIED;
        if (k == KIND_POLL)
        begin
            if (p_try_seen && (t - p_last_try) < {16'd0, p_poll_iv})
                st = ST_THROTTLED;
            else
            begin
                p_try_seen = 1;
                p_last_try = t;
                if (!rdy)
                begin
                    if (p_healthy && (t - p_last_ok) > {12'd0, p_silence})
                        p_healthy = 0;
                    st = ST_MISSED;
                end
                else
                begin
                    p_healthy = 1;
                    p_last_ok = t;
                    p_last_raw = raw;
                    if (p_scale != 0)
                    begin
                        diff = longint'(p_last_raw) - longint'(p_offset);
                        p_weight = clamp40(div_nearest(diff * 1048576,
                                                       longint'({34'd0, p_scale})));
                    end
                    if (!p_sample_seen || (t - p_last_sample) >= {12'd0, p_hist_iv})
                        history_push(t);
                end
            end
        end
        else if (k == KIND_TARE)
        begin
            if (!p_healthy)
                st = ST_REJECTED;
            else
            begin
                p_offset = p_last_raw;
                p_weight = '0;
                p_held = 0;
                p_slot = 0;
                p_rate = '0;
                p_rate_known = 0;
            end
        end
        else if (k == KIND_CAL)
        begin
            diff = longint'(p_last_raw) - longint'(p_offset);
            if (!p_healthy || grams == 0 || diff * 20 <= longint'(grams)
                    || diff >= longint'(grams) * 200000)
                st = ST_REJECTED;
            else
                p_scale = 30'(div_nearest(diff * 4096, longint'(grams)));
        end
        else
            st = ST_REJECTED;
        r.weight = p_weight;
        r.rate = p_rate_known ? p_rate : '0;
        r.rate_ok = p_rate_known;
        r.healthy = p_healthy;
        r.st = st;
        return r;
    endfunction

    // Send one item and record its expected result; valid stays high after
    // acceptance until the next item or an idle gap replaces it
    task automatic send_item(input logic [1:0] k, input logic [31:0] t,
            input logic rdy, input logic signed [23:0] raw, input logic [19:0] grams);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        now_ms <= t;
        data_ready <= rdy;
        raw_sample <= raw;
        known_grams <= grams;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(tracker_step(k, t, rdy, raw, grams));
    endtask

    task automatic poll_at(input int step_ms, input logic rdy,
            input logic signed [23:0] raw);
        clock_ms = clock_ms + step_ms;
        send_item(KIND_POLL, clock_ms, rdy, raw, '0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_POLL:    p_poll_iv = val[15:0];
            REG_SILENCE: p_silence = val;
            REG_HIST:    p_hist_iv = val;
            default:     p_span = val;
        endcase
    endtask

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        tracker_result_t exp_r;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (weight_grams !== exp_r.weight)
                begin
                    $error("weight_grams exp %0d got %0d", exp_r.weight, weight_grams);
                    error_count++;
                end
                if (rate_grams_per_min !== exp_r.rate)
                begin
                    $error("rate_grams_per_min exp %0d got %0d", exp_r.rate,
                           rate_grams_per_min);
                    error_count++;
                end
                if (rate_valid !== exp_r.rate_ok)
                begin
                    $error("rate_valid exp %0b got %0b", exp_r.rate_ok, rate_valid);
                    error_count++;
                end
                if (sensor_ok !== exp_r.healthy)
                begin
                    $error("sensor_ok exp %0b got %0b", exp_r.healthy, sensor_ok);
                    error_count++;
                end
                if (status !== exp_r.st)
                begin
                    $error("status exp %0d got %0d", exp_r.st, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int wait_left;
        out_ready = 1'b0;
        wait_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles--;
                out_ready <= 1'b0;
            end
            else if (out_ready && out_valid || !out_ready && wait_left == 0)
            begin
                wait_left = rx_idle_on ? $urandom_range(0, 14) : 0;
                out_ready <= (wait_left == 0);
            end
            else if (!out_ready)
            begin
                wait_left--;
                out_ready <= (wait_left == 0);
            end
        end
    end

    // Corner cases of health, throttle, tare and calibrate
    task automatic test_directed();
        send_item(KIND_TARE, clock_ms, 1'b0, 24'sd0, 20'd0);     // rejected, unhealthy
        send_item(KIND_CAL, clock_ms, 1'b0, 24'sd0, 20'd1000);   // rejected, unhealthy
        poll_at(1, 1'b0, 24'sd0);                                // missed, first poll
        poll_at(1, 1'b1, 24'sh7FFFFF);                           // throttled
        poll_at(600, 1'b1, 24'sh7FFFFF);
        poll_at(600, 1'b1, 24'sh800000);
        poll_at(600, 1'b1, 24'sd1000);
        send_item(KIND_TARE, clock_ms, 1'b0, 24'sd0, 20'd0);
        poll_at(30000, 1'b1, 24'sd5096);
        send_item(KIND_CAL, clock_ms, 1'b0, 24'sd0, 20'd0);      // zero mass
        send_item(KIND_CAL, clock_ms, 1'b0, 24'sd0, 20'hFFFFF);  // ratio too small
        send_item(KIND_CAL, clock_ms, 1'b0, 24'sd0, 20'd1);
        send_item(KIND_CAL, clock_ms, 1'b0, 24'sd0, 20'd2);
        send_item(KIND_CAL, clock_ms, 1'b0, 24'sd0, 20'd1000);
        poll_at(30000, 1'b1, 24'sd9096);
        send_item(KIND_UNKNOWN, clock_ms, 1'b1, 24'sd5, 20'd5);  // unknown kind
        poll_at(30000, 1'b1, 24'sd13096);
        poll_at(30000, 1'b1, 24'sd1);
        poll_at(5000, 1'b0, 24'sd0);
        poll_at(6000, 1'b0, 24'sd0);                             // silence timeout
        poll_at(32'hFFFFFF00, 1'b1, 24'sd77);                    // time wraps
        send_item(KIND_CAL, clock_ms, 1'b0, 24'sd0, 20'd50);
        drain();
    endtask

    // Random traffic with mostly well-spaced polls
    task automatic test_random(input int count);
        int sel;
        logic signed [23:0] base;
        base = 24'($urandom);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                base = base + 24'($urandom_range(0, 4000)) - 24'sd2000;
                clock_ms = clock_ms + $urandom_range(0, 2 * p_hist_iv + 100);
                send_item(KIND_POLL, clock_ms, $urandom_range(0, 9) != 0,
                          ($urandom_range(0, 9) == 0) ? 24'($urandom) : base, '0);
            end
            else if (sel < 80)
            begin
                clock_ms = clock_ms + $urandom_range(0, 700);
                send_item(KIND_POLL, clock_ms, 1'($urandom_range(0, 1)),
                          24'($urandom), '0);
            end
            else if (sel < 84)
                send_item(KIND_TARE, clock_ms, 1'b0, 24'($urandom), 20'($urandom));
            else if (sel < 96)
                send_item(KIND_CAL, clock_ms, 1'($urandom_range(0, 1)), 24'($urandom),
                          ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                      : 20'($urandom_range(0, 3000)));
            else
            begin
                clock_ms = $urandom;
                send_item(2'($urandom), clock_ms, 1'($urandom_range(0, 1)),
                          24'($urandom), 20'($urandom));
            end
        end
        drain();
    endtask

    // Long receiver stall fills the block, then a full sender pause
    task automatic test_backpressure();
        holdoff_cycles = 3000;
        for (int i = 0; i < 20; i++)
            poll_at(p_hist_iv, 1'b1, 24'($urandom_range(0, 50000)));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_POLL;
        now_ms = '0;
        data_ready = 1'b0;
        raw_sample = '0;
        known_grams = '0;
        cfg_we = 1'b0;
        cfg_index = REG_POLL;
        cfg_data = '0;
        error_count = 0;
        results_seen = 0;
        holdoff_cycles = 0;
        rate_updates = 0;
        rx_idle_on = 1;
        tx_idle_on = 1;
        clock_ms = 32'd1000;
        tracker_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_reg(REG_POLL, 20'd0);
        write_reg(REG_SILENCE, 20'd0);
        write_reg(REG_HIST, 20'd1);
        write_reg(REG_SPAN, 20'd1);
        test_random(400);
        write_reg(REG_POLL, 20'hFFFF);
        write_reg(REG_SILENCE, 20'hFFFFF);
        write_reg(REG_HIST, 20'd1000);
        write_reg(REG_SPAN, 20'd2500);
        rx_idle_on = 0;
        tx_idle_on = 0;
        test_random(300);
        rx_idle_on = 1;
        tx_idle_on = 1;
        test_backpressure();
        write_reg(REG_POLL, 20'd500);
        write_reg(REG_SILENCE, 20'd3000);
        write_reg(REG_HIST, 20'd2000);
        write_reg(REG_SPAN, 20'd5000);
        test_random(600);
        write_reg(REG_POLL, 20'd200);
        write_reg(REG_SILENCE, 20'd10000);
        write_reg(REG_HIST, 20'hFFFFF);
        write_reg(REG_SPAN, 20'hFFFFF);
        test_random(550);

        $display("run covered %0d result transactions, %0d rate updates, %0d mismatches",
                 results_seen, rate_updates, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[load_cell_weight_rate_tracker_top] OK");
        else
            $display("[load_cell_weight_rate_tracker_top] ERROR");
        $finish;
    end
endmodule
